### src/prt_pkg.sv
package prt_pkg;

    localparam int USEC_W = 52;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 40;

    localparam logic [1:0] ACT_PING = 2'd0;
    localparam logic [1:0] ACT_PONG = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RESULTS = 1'd1;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = 52'd1000000;

    localparam logic [39:0] THRESHOLD_RST = 40'd120000000;
    localparam logic [7:0]  MIN_RESULTS_RST = 8'd20;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         peer;
        logic [31:0]        seq;
        logic [63:0]        now_ts;
        logic signed [47:0] rtt;
        logic signed [47:0] off;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic [31:0]        seq_out;
        logic [63:0]        ts_out;
        logic signed [47:0] rtt_us;
        logic signed [47:0] offset_us;
        logic signed [47:0] mean_offset_us;
        logic               mean_valid;
        logic               shift_alarm;
        logic               late_pong;
        logic [31:0]        sent_count;
        logic [31:0]        lost_count;
    } result_t;

    function automatic logic [USEC_W-1:0] to_usec(input logic [63:0] packed_ts);
        logic [USEC_W-1:0] secs;
        logic [USEC_W-1:0] usecs;
        secs = USEC_W'(packed_ts[63:32]);
        usecs = USEC_W'(packed_ts[31:0]);
        return secs * USEC_PER_SEC + usecs;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
        logic signed [47:0] r;
        if (v > 54'sd140737488355327)
        begin
            r = 48'sh7fffffffffff;
        end
        else if (v < -54'sd140737488355328)
        begin
            r = 48'sh800000000000;
        end
        else
        begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

### src/prt_if.sv
interface prt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [5:0]  peer;
    logic [31:0] seq_no;
    logic [63:0] now_ts;
    logic [63:0] ping_ts;
    logic [63:0] pong_ts;

    modport source (output valid, action, peer, seq_no, now_ts, ping_ts, pong_ts,
                    input ready);
    modport sink (input valid, action, peer, seq_no, now_ts, ping_ts, pong_ts,
                  output ready);
endinterface

interface prt_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [31:0]        seq_out;
    logic [63:0]        ts_out;
    logic signed [47:0] rtt_us;
    logic signed [47:0] offset_us;
    logic signed [47:0] mean_offset_us;
    logic               mean_valid;
    logic               shift_alarm;
    logic               late_pong;
    logic [31:0]        sent_count;
    logic [31:0]        lost_count;

    modport source (output valid, kind, seq_out, ts_out, rtt_us, offset_us,
                    mean_offset_us, mean_valid, shift_alarm, late_pong,
                    sent_count, lost_count, input ready);
    modport sink (input valid, kind, seq_out, ts_out, rtt_us, offset_us,
                  mean_offset_us, mean_valid, shift_alarm, late_pong,
                  sent_count, lost_count, output ready);
endinterface

interface prt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [prt_pkg::CFG_ADDR_W-1:0] addr;
    logic [prt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

### src/prt_ram.sv
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### src/prt_fifo.sv
module prt_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  prt_pkg::cmd_t push_data,
    input  logic          pop,
    output prt_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    localparam int DEPTH = 2;

    prt_pkg::cmd_t entry_reg [DEPTH];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign full = (fill_reg == 2'(DEPTH));
    assign empty = (fill_reg == 2'd0);
endmodule

### src/prt_div.sv
module prt_div #(
    parameter int N = 56,
    parameter int M = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [M-1:0] divisor,
    output logic         busy,
    output logic         done,
    output logic [N-1:0] quotient
);
    localparam int SW = $clog2(N + 1);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic [N-1:0]  q_reg;
    logic [N-1:0]  q_next;
    logic [M-1:0]  r_reg;
    logic [M-1:0]  r_next;
    logic [M-1:0]  d_reg;
    logic [M-1:0]  d_next;
    logic [M:0]    r_sh;
    logic          ge;

    assign r_sh = {r_reg, q_reg[N-1]};
    assign ge = (r_sh >= {1'b0, d_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[N-2:0], ge};
            r_next = ge ? M'(r_sh - {1'b0, d_reg}) : M'(r_sh);
            step_next = step_reg + SW'(1);
            if (step_reg == SW'(N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = q_reg;
endmodule

### src/prt_front.sv
module prt_front #(
    parameter int PEERS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    prt_in_if.sink        req,
    input  logic          clearing,
    input  logic          q_full,
    output logic          q_push,
    output prt_pkg::cmd_t q_data
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_CMP  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]                  st_reg;
    logic [1:0]                  st_next;
    logic [1:0]                  action_reg;
    logic [5:0]                  peer_reg;
    logic [31:0]                 seq_reg;
    logic [63:0]                 now_ts_reg;
    logic [63:0]                 ping_ts_reg;
    logic [63:0]                 pong_ts_reg;
    logic [prt_pkg::USEC_W-1:0] now_us_reg;
    logic [prt_pkg::USEC_W-1:0] ping_us_reg;
    logic [prt_pkg::USEC_W-1:0] pong_us_reg;
    logic signed [47:0]          rtt_reg;
    logic signed [47:0]          off_reg;
    logic                        accept;
    logic                        peer_ok;
    logic [prt_pkg::USEC_W:0]   sum_us;
    logic signed [53:0]          rtt_full;
    logic signed [53:0]          off_full;

    assign req.ready = (st_reg == F_IDLE) && !clearing;
    assign accept = req.valid && req.ready;
    assign peer_ok = (32'(req.peer) < PEERS);

    assign sum_us = {1'b0, now_us_reg} + {1'b0, ping_us_reg};
    assign rtt_full = $signed({2'b00, now_us_reg}) - $signed({2'b00, ping_us_reg});
    assign off_full = $signed({2'b00, pong_us_reg})
                    - $signed({2'b00, sum_us[prt_pkg::USEC_W:1]});

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == prt_pkg::ACT_END)
                    begin
                        st_next = F_PUSH;
                    end
                    else if ((req.action inside {prt_pkg::ACT_PING, prt_pkg::ACT_PONG})
                             && peer_ok)
                    begin
                        st_next = F_MUL;
                    end
                end
            end
            F_MUL:
            begin
                st_next = F_CMP;
            end
            F_CMP:
            begin
                st_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    st_next = F_IDLE;
                end
            end
            default:
            begin
                st_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= F_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= req.action;
            peer_reg <= req.peer;
            seq_reg <= req.seq_no;
            now_ts_reg <= req.now_ts;
            ping_ts_reg <= req.ping_ts;
            pong_ts_reg <= req.pong_ts;
        end
        if (st_reg == F_MUL)
        begin
            now_us_reg <= prt_pkg::to_usec(now_ts_reg);
            ping_us_reg <= prt_pkg::to_usec(ping_ts_reg);
            pong_us_reg <= prt_pkg::to_usec(pong_ts_reg);
        end
        if (st_reg == F_CMP)
        begin
            rtt_reg <= prt_pkg::sat48(rtt_full);
            off_reg <= prt_pkg::sat48(off_full);
        end
    end

    assign q_push = (st_reg == F_PUSH) && !q_full;
    assign q_data = '{action: action_reg, peer: peer_reg, seq: seq_reg,
                      now_ts: now_ts_reg, rtt: rtt_reg, off: off_reg};
endmodule

### src/prt_back.sv
module prt_back #(
    parameter int PEERS = 64,
    parameter int WINDOW = 150
) (
    input  logic          clk,
    input  logic          rst_n,
    input  prt_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    output logic          clearing,
    prt_out_if.source     rsp,
    prt_cfg_if.sink       cfg
);
    localparam int HEAD_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = 48 + $clog2(WINDOW);
    localparam int PA_W = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int WA_W = (PEERS * WINDOW > 1) ? $clog2(PEERS * WINDOW) : 1;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RD   = 3'd1;
    localparam logic [2:0] B_WIN  = 3'd2;
    localparam logic [2:0] B_UPD  = 3'd3;
    localparam logic [2:0] B_MAG  = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    typedef struct packed {
        logic [HEAD_W-1:0]       head;
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [31:0]             ping_seq;
        logic                    seen;
        logic [31:0]             sent;
        logic [31:0]             lost;
    } ps_t;

    localparam int PS_W = $bits(ps_t);

    logic [2:0]            st_reg;
    logic [2:0]            st_next;
    prt_pkg::cmd_t         cmd_reg;
    prt_pkg::cmd_t         cmd_next;
    ps_t                   ps_reg;
    ps_t                   ps_next;
    logic                  late_reg;
    logic                  late_next;
    logic [WA_W-1:0]       waddr_reg;
    logic [WA_W-1:0]       waddr_next;
    logic [31:0]           rnd_reg;
    logic [31:0]           rnd_next;
    logic [39:0]           thr_reg;
    logic [39:0]           thr_next;
    logic [7:0]            minr_reg;
    logic [7:0]            minr_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  neg_reg;
    logic                  neg_next;
    prt_pkg::result_t      pend_reg;
    prt_pkg::result_t      pend_next;
    prt_pkg::result_t      res_reg;
    prt_pkg::result_t      res_next;
    logic                  ovld_reg;
    logic                  ovld_next;
    logic                  clr_busy_reg;
    logic                  clr_busy_next;
    logic [PA_W-1:0]       clr_idx_reg;
    logic [PA_W-1:0]       clr_idx_next;

    logic                  ps_we;
    logic [PA_W-1:0]       ps_waddr;
    ps_t                   ps_wdata;
    logic [PA_W-1:0]       ps_raddr;
    logic [PS_W-1:0]       ps_rdata_raw;
    ps_t                   ps_rdata;
    logic                  win_we;
    logic [WA_W-1:0]       win_raddr;
    logic [47:0]           win_rdata;
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [SUM_W-1:0]      div_q;
    logic [SUM_W-1:0]      sum_mag;
    logic [HEAD_W-1:0]     head_fix;
    ps_t                   ps_upd;
    ps_t                   ps_init;
    prt_pkg::result_t      pong_res;
    logic [47:0]           q48;

    assign ps_rdata = ps_t'(ps_rdata_raw);
    assign head_fix = (32'(ps_rdata.head) >= WINDOW) ? '0 : ps_rdata.head;
    assign sum_mag = ps_reg.sum[SUM_W-1] ? SUM_W'(-ps_reg.sum) : SUM_W'(ps_reg.sum);
    assign q48 = div_q[47:0];
    assign ps_raddr = PA_W'(cmd.peer);
    assign win_raddr = WA_W'(WA_W'(cmd_reg.peer) * WA_W'(WINDOW)) + WA_W'(head_fix);

    always_comb
    begin
        ps_init = '0;
        ps_init.seen = 1'b1;
    end

    always_comb
    begin
        ps_upd = ps_reg;
        ps_upd.sum = ps_reg.sum + SUM_W'(cmd_reg.off);
        ps_upd.head = (32'(ps_reg.head) == WINDOW - 1) ? '0 : ps_reg.head + HEAD_W'(1);
    end

    always_comb
    begin
        pong_res = '0;
        pong_res.kind = 1'b1;
        pong_res.rtt_us = cmd_reg.rtt;
        pong_res.offset_us = cmd_reg.off;
        pong_res.late_pong = late_reg;
        pong_res.sent_count = ps_reg.sent;
        pong_res.lost_count = ps_reg.lost;
    end

    always_comb
    begin
        st_next = st_reg;
        cmd_next = cmd_reg;
        ps_next = ps_reg;
        late_next = late_reg;
        waddr_next = waddr_reg;
        rnd_next = rnd_reg;
        thr_next = thr_reg;
        minr_next = minr_reg;
        valid_next = valid_reg;
        neg_next = neg_reg;
        pend_next = pend_reg;
        res_next = res_reg;
        ovld_next = ovld_reg;
        clr_busy_next = clr_busy_reg;
        clr_idx_next = clr_idx_reg;
        cmd_pop = 1'b0;
        ps_we = 1'b0;
        ps_waddr = PA_W'(cmd_reg.peer);
        ps_wdata = ps_reg;
        win_we = 1'b0;
        div_start = 1'b0;

        if (cfg.valid)
        begin
            case (cfg.addr)
                prt_pkg::REG_THRESHOLD:
                begin
                    thr_next = cfg.data;
                end
                prt_pkg::REG_MIN_RESULTS:
                begin
                    minr_next = cfg.data[7:0];
                end
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end

        if (rsp.ready)
        begin
            ovld_next = 1'b0;
        end

        if (clr_busy_reg)
        begin
            ps_we = 1'b1;
            ps_waddr = clr_idx_reg;
            ps_wdata = ps_init;
            clr_idx_next = clr_idx_reg + PA_W'(1);
            if (clr_idx_reg == PA_W'(PEERS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        case (st_reg)
            B_IDLE:
            begin
                if (!clr_busy_reg && cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    cmd_next = cmd;
                    st_next = B_RD;
                end
            end
            B_RD:
            begin
                if (cmd_reg.action == prt_pkg::ACT_END)
                begin
                    rnd_next = rnd_reg + 32'd1;
                    st_next = B_IDLE;
                end
                else if (cmd_reg.action == prt_pkg::ACT_PING)
                begin
                    ps_wdata = ps_rdata;
                    ps_wdata.ping_seq = rnd_reg;
                    ps_wdata.sent = ps_rdata.sent + 32'd1;
                    ps_wdata.lost = ps_rdata.lost + {31'd0, !ps_rdata.seen};
                    ps_wdata.seen = 1'b0;
                    ps_we = 1'b1;
                    pend_next = '0;
                    pend_next.seq_out = rnd_reg;
                    pend_next.ts_out = cmd_reg.now_ts;
                    pend_next.sent_count = ps_wdata.sent;
                    pend_next.lost_count = ps_wdata.lost;
                    st_next = B_OUT;
                end
                else
                begin
                    late_next = (cmd_reg.seq != ps_rdata.ping_seq);
                    ps_next = ps_rdata;
                    ps_next.head = head_fix;
                    if (cmd_reg.seq == ps_rdata.ping_seq)
                    begin
                        ps_next.seen = 1'b1;
                    end
                    waddr_next = win_raddr;
                    st_next = B_WIN;
                end
            end
            B_WIN:
            begin
                if (32'(ps_reg.count) >= WINDOW)
                begin
                    ps_next.sum = ps_reg.sum - SUM_W'($signed(win_rdata));
                    ps_next.count = CNT_W'(WINDOW);
                end
                else
                begin
                    ps_next.count = ps_reg.count + CNT_W'(1);
                end
                st_next = B_UPD;
            end
            B_UPD:
            begin
                ps_we = 1'b1;
                ps_wdata = ps_upd;
                ps_next = ps_upd;
                win_we = 1'b1;
                valid_next = (32'(ps_reg.count) > 32'(minr_reg));
                st_next = B_MAG;
            end
            B_MAG:
            begin
                if (valid_reg)
                begin
                    div_start = 1'b1;
                    neg_next = ps_reg.sum[SUM_W-1];
                    st_next = B_DIV;
                end
                else
                begin
                    pend_next = pong_res;
                    st_next = B_OUT;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    pend_next = pong_res;
                    pend_next.mean_offset_us = neg_reg ? $signed(-q48) : $signed(q48);
                    pend_next.mean_valid = 1'b1;
                    pend_next.shift_alarm = (q48 > {8'd0, thr_reg});
                    st_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!ovld_reg || rsp.ready)
                begin
                    res_next = pend_reg;
                    ovld_next = 1'b1;
                    st_next = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            rnd_reg <= '0;
            thr_reg <= prt_pkg::THRESHOLD_RST;
            minr_reg <= prt_pkg::MIN_RESULTS_RST;
            ovld_reg <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            rnd_reg <= rnd_next;
            thr_reg <= thr_next;
            minr_reg <= minr_next;
            ovld_reg <= ovld_next;
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ps_reg <= ps_next;
        late_reg <= late_next;
        waddr_reg <= waddr_next;
        valid_reg <= valid_next;
        neg_reg <= neg_next;
        pend_reg <= pend_next;
        res_reg <= res_next;
    end

    prt_ram #(.WIDTH(PS_W), .DEPTH(PEERS)) u_peer_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (PS_W'(ps_wdata)),
        .raddr (ps_raddr),
        .rdata (ps_rdata_raw)
    );

    prt_ram #(.WIDTH(48), .DEPTH(PEERS * WINDOW)) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (waddr_reg),
        .wdata (cmd_reg.off),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    prt_div #(.N(SUM_W), .M(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (ps_reg.count),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign clearing = clr_busy_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = ovld_reg;
    assign rsp.kind = res_reg.kind;
    assign rsp.seq_out = res_reg.seq_out;
    assign rsp.ts_out = res_reg.ts_out;
    assign rsp.rtt_us = res_reg.rtt_us;
    assign rsp.offset_us = res_reg.offset_us;
    assign rsp.mean_offset_us = res_reg.mean_offset_us;
    assign rsp.mean_valid = res_reg.mean_valid;
    assign rsp.shift_alarm = res_reg.shift_alarm;
    assign rsp.late_pong = res_reg.late_pong;
    assign rsp.sent_count = res_reg.sent_count;
    assign rsp.lost_count = res_reg.lost_count;

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovld_reg) |-> $past(st_reg) == B_OUT)
        else $error("Result register loaded outside the output step.");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !cmd_pop)
        else $error("Command taken during the clearing pass.");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("Divider restarted while busy.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == B_UPD |-> (ps_reg.count != '0) && (32'(ps_reg.count) <= WINDOW))
        else $error("Window count out of range.");
endmodule

### src/peer_rtt_offset_tracker.sv
// Per-peer ping/pong round-trip and clock-offset tracker.
// Items arrive on req (valid/ready): ping, pong or end of round for a peer.
// Pings and pongs give one item on rsp; end of round and unknown actions or
// peers outside the table give none. Registers are written through cfg, whose
// ready is always high; write them only while the block is idle.
// The front stage converts the timestamps to microseconds and computes the
// round trip and offset, then hands a command to a two-entry queue. The back
// stage reads the peer record and, for a pong, the offset window memory,
// updates both and divides the window sum by the count bit by bit. A ping
// passes B_RD and B_OUT; a pong B_RD, B_WIN, B_UPD, B_MAG, B_DIV while the
// serial divider runs (valid mean only) and B_OUT. Each stage takes one
// item at a time, but the front can take the next item while the back works
// on the last. After reset the peer table is cleared, one peer per cycle,
// and req.ready stays low until done. When rsp stalls, one result waits
// in the output register while the next item proceeds until it needs it.
module peer_rtt_offset_tracker #(
    parameter int PEERS = 64,
    parameter int WINDOW = 150
) (
    input logic       clk,
    input logic       rst_n,
    prt_in_if.sink    req,
    prt_out_if.source rsp,
    prt_cfg_if.sink   cfg
);
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic          clearing;
    prt_pkg::cmd_t q_in;
    prt_pkg::cmd_t q_out;

    prt_front #(.PEERS(PEERS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    prt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    prt_back #(.PEERS(PEERS), .WINDOW(WINDOW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_out),
        .cmd_valid (!q_empty),
        .cmd_pop   (q_pop),
        .clearing  (clearing),
        .rsp       (rsp),
        .cfg       (cfg)
    );
endmodule

### verif/peer_rtt_offset_tracker_test.sv
module peer_rtt_offset_tracker_test;
    localparam int NPEER = 64;
    localparam int WIN = 150;
    localparam int EXP_DEPTH = 2048;
    localparam int MAX_ROWS = 16;
    localparam longint S48_HI = 64'sd140737488355327;
    localparam longint S48_LO = -64'sd140737488355328;
    localparam logic [1:0] ACT_BAD = 2'd3;

    typedef struct {
        logic [1:0]  action;
        logic [5:0]  peer;
        logic [31:0] seq;
        logic [63:0] now_ts;
        logic [63:0] ping_ts;
        logic [63:0] pong_ts;
        bit          typed;
        prt_pkg::result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    prt_in_if req ();
    prt_out_if rsp ();
    prt_cfg_if cfg ();

    peer_rtt_offset_tracker dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .cfg(cfg)
    );

    // Shadow of the tracker state.
    longint      threshold_us;
    int          min_count;
    logic [31:0] round_no;
    longint      offsets [NPEER][WIN];
    int          head_idx [NPEER];
    int          fill [NPEER];
    longint      sum_us [NPEER];
    logic [31:0] ping_seq_tab [NPEER];
    bit          answered [NPEER];
    logic [31:0] sent_tab [NPEER];
    logic [31:0] lost_tab [NPEER];

    prt_pkg::result_t exp_q [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          alarms_seen = 0;
    int          valid_means = 0;
    bit          idle_on = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    logic [63:0] clock_us;

    always #5 clk = ~clk;

    function automatic longint usec_of(logic [63:0] p);
        return longint'({32'd0, p[63:32]}) * 1000000 + longint'({32'd0, p[31:0]});
    endfunction

    function automatic logic [63:0] pack_us(longint us);
        longint s;
        s = us / 1000000;
        return {s[31:0], 32'(us - s * 1000000)};
    endfunction

    function automatic longint clip48(longint v);
        if (v > S48_HI)
        begin
            return S48_HI;
        end
        if (v < S48_LO)
        begin
            return S48_LO;
        end
        return v;
    endfunction

    function automatic bit track_item(input stim_row_t it, output prt_pkg::result_t r);
        int p;
        int h;
        longint now_us;
        longint ping_us;
        longint off;
        longint mean;
        longint mag;
        bit late;
        bit ok;
        p = int'(it.peer);
        r = '0;
        if (it.action == prt_pkg::ACT_END)
        begin
            round_no = round_no + 32'd1;
            return 1'b0;
        end
        if (it.action == ACT_BAD)
        begin
            return 1'b0;
        end
        if (it.action == prt_pkg::ACT_PING)
        begin
            ping_seq_tab[p] = round_no;
            sent_tab[p] = sent_tab[p] + 32'd1;
            if (!answered[p])
            begin
                lost_tab[p] = lost_tab[p] + 32'd1;
            end
            answered[p] = 1'b0;
            r.kind = 1'b0;
            r.seq_out = round_no;
            r.ts_out = it.now_ts;
            r.sent_count = sent_tab[p];
            r.lost_count = lost_tab[p];
            return 1'b1;
        end
        now_us = usec_of(it.now_ts);
        ping_us = usec_of(it.ping_ts);
        off = clip48(usec_of(it.pong_ts) - ((now_us + ping_us) >>> 1));
        late = it.seq != ping_seq_tab[p];
        if (!late)
        begin
            answered[p] = 1'b1;
        end
        h = head_idx[p];
        if (h >= WIN)
        begin
            h = 0;
        end
        if (fill[p] >= WIN)
        begin
            sum_us[p] -= offsets[p][h];
            fill[p] = WIN;
        end
        else
        begin
            fill[p]++;
        end
        offsets[p][h] = off;
        sum_us[p] += off;
        h++;
        head_idx[p] = (h >= WIN) ? 0 : h;
        ok = fill[p] > min_count;
        mean = ok ? sum_us[p] / fill[p] : 0;
        mag = (mean < 0) ? -mean : mean;
        r.kind = 1'b1;
        r.rtt_us = 48'(clip48(now_us - ping_us));
        r.offset_us = 48'(off);
        r.mean_offset_us = 48'(mean);
        r.mean_valid = ok;
        r.shift_alarm = ok && (mag > threshold_us);
        r.late_pong = late;
        r.sent_count = sent_tab[p];
        r.lost_count = lost_tab[p];
        return 1'b1;
    endfunction

    task automatic send_item(input stim_row_t it);
        prt_pkg::result_t r;
        req.action <= it.action;
        req.peer <= it.peer;
        req.seq_no <= it.seq;
        req.now_ts <= it.now_ts;
        req.ping_ts <= it.ping_ts;
        req.pong_ts <= it.pong_ts;
        req.valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        items_sent++;
        if (track_item(it, r))
        begin
            exp_q[exp_wr % EXP_DEPTH] = it.typed ? it.want : r;
            exp_wr++;
        end
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (exp_wr != exp_rd)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic set_config(input logic [39:0] thr, input logic [7:0] minr);
        cfg.addr <= prt_pkg::REG_THRESHOLD;
        cfg.data <= thr;
        cfg.valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        cfg.addr <= prt_pkg::REG_MIN_RESULTS;
        cfg.data <= {32'd0, minr};
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        threshold_us = longint'({24'd0, thr});
        min_count = int'(minr);
    endtask

    function automatic stim_row_t mk(logic [1:0] a, logic [5:0] p, logic [31:0] s,
                                     logic [63:0] n, logic [63:0] pi, logic [63:0] po);
        stim_row_t it;
        it.action = a;
        it.peer = p;
        it.seq = s;
        it.now_ts = n;
        it.ping_ts = pi;
        it.pong_ts = po;
        it.typed = 1'b0;
        it.want = '0;
        return it;
    endfunction

    function automatic logic [5:0] pick_peer();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 6'd0;
        end
        if (r < 85)
        begin
            return 6'($urandom_range(1, 3));
        end
        return 6'($urandom_range(0, NPEER - 1));
    endfunction

    task automatic random_part(input int n_items, input longint spread_us);
        stim_row_t it;
        logic [5:0] p;
        longint t_us;
        longint now_us;
        int r;
        int done_items;
        done_items = 0;
        while (done_items < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                it = mk(2'($urandom_range(0, 3)), 6'($urandom), $urandom,
                        {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
                send_item(it);
                maybe_gap();
                done_items++;
            end
            else if (r < 8)
            begin
                send_item(mk(prt_pkg::ACT_END, 6'($urandom), $urandom, 0, 0, 0));
                maybe_gap();
                done_items++;
            end
            else
            begin
                p = pick_peer();
                clock_us = clock_us + $urandom_range(1, 5000000);
                t_us = longint'(clock_us);
                send_item(mk(prt_pkg::ACT_PING, p, $urandom, pack_us(t_us), 0, 0));
                maybe_gap();
                done_items++;
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(mk(prt_pkg::ACT_END, p, 0, 0, 0, 0));
                    maybe_gap();
                    done_items++;
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    now_us = t_us + $urandom_range(0, 2000000);
                    it = mk(prt_pkg::ACT_PONG, p,
                            ($urandom_range(0, 9) == 0) ? $urandom : ping_seq_tab[p],
                            pack_us(now_us), pack_us(t_us),
                            pack_us((now_us + t_us) / 2
                                    + longint'($urandom_range(0, 2 * spread_us))
                                    - spread_us));
                    send_item(it);
                    maybe_gap();
                    done_items++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (long_hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
        end
    end

    task automatic report(input string name, input logic [63:0] e, input logic [63:0] a);
        $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, e, a);
        errors++;
    endtask

    always @(posedge clk)
    begin
        prt_pkg::result_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (rsp.shift_alarm)
            begin
                alarms_seen++;
            end
            if (rsp.mean_valid)
            begin
                valid_means++;
            end
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result item, expected none, actual kind %b",
                         $time, rsp.kind);
                errors++;
            end
            else
            begin
                e = exp_q[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (e.kind !== rsp.kind) report("kind", e.kind, rsp.kind);
                if (e.seq_out !== rsp.seq_out) report("seq_out", e.seq_out, rsp.seq_out);
                if (e.ts_out !== rsp.ts_out) report("ts_out", e.ts_out, rsp.ts_out);
                if (e.rtt_us !== rsp.rtt_us) report("rtt_us", e.rtt_us, rsp.rtt_us);
                if (e.offset_us !== rsp.offset_us)
                    report("offset_us", e.offset_us, rsp.offset_us);
                if (e.mean_offset_us !== rsp.mean_offset_us)
                    report("mean_offset_us", e.mean_offset_us, rsp.mean_offset_us);
                if (e.mean_valid !== rsp.mean_valid)
                    report("mean_valid", e.mean_valid, rsp.mean_valid);
                if (e.shift_alarm !== rsp.shift_alarm)
                    report("shift_alarm", e.shift_alarm, rsp.shift_alarm);
                if (e.late_pong !== rsp.late_pong)
                    report("late_pong", e.late_pong, rsp.late_pong);
                if (e.sent_count !== rsp.sent_count)
                    report("sent_count", e.sent_count, rsp.sent_count);
                if (e.lost_count !== rsp.lost_count)
                    report("lost_count", e.lost_count, rsp.lost_count);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t rows [MAX_ROWS];
        stim_row_t it;
        int n_rows;
        n_rows = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.action = prt_pkg::ACT_PING;
        req.peer = '0;
        req.seq_no = '0;
        req.now_ts = '0;
        req.ping_ts = '0;
        req.pong_ts = '0;
        cfg.valid = 1'b0;
        cfg.addr = prt_pkg::REG_THRESHOLD;
        cfg.data = '0;
        threshold_us = 120000000;
        min_count = 20;
        round_no = '0;
        clock_us = 64'd1000000000;
        for (int p = 0; p < NPEER; p++)
        begin
            head_idx[p] = 0;
            fill[p] = 0;
            sum_us[p] = 0;
            ping_seq_tab[p] = '0;
            answered[p] = 1'b1;
            sent_tab[p] = '0;
            lost_tab[p] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        it = mk(prt_pkg::ACT_PING, 6'd0, 0, 64'h1_0000_0000, 0, 0);
        it.typed = 1'b1;
        it.want.ts_out = 64'h1_0000_0000;
        it.want.sent_count = 1;
        rows[n_rows] = it;
        n_rows++;
        it = mk(prt_pkg::ACT_PING, 6'd0, 0, 64'h2_0000_0000, 0, 0);
        it.typed = 1'b1;
        it.want.ts_out = 64'h2_0000_0000;
        it.want.sent_count = 2;
        it.want.lost_count = 1;
        rows[n_rows] = it;
        n_rows++;
        rows[n_rows] = mk(prt_pkg::ACT_END, 6'd0, 0, 0, 0, 0);
        n_rows++;
        it = mk(prt_pkg::ACT_PING, 6'd63, 0, '1, 0, 0);
        it.typed = 1'b1;
        it.want.seq_out = 1;
        it.want.ts_out = '1;
        it.want.sent_count = 1;
        rows[n_rows] = it;
        n_rows++;
        it = mk(prt_pkg::ACT_PONG, 6'd63, 1, 0, 0, 0);
        it.typed = 1'b1;
        it.want.kind = 1'b1;
        it.want.sent_count = 1;
        rows[n_rows] = it;
        n_rows++;
        it = mk(prt_pkg::ACT_PONG, 6'd63, 5, '1, 0, 0);
        it.typed = 1'b1;
        it.want.kind = 1'b1;
        it.want.rtt_us = 48'sh7fffffffffff;
        it.want.offset_us = 48'sh800000000000;
        it.want.late_pong = 1'b1;
        it.want.sent_count = 1;
        rows[n_rows] = it;
        n_rows++;
        it = mk(prt_pkg::ACT_PONG, 6'd1, 0, 0, '1, '1);
        it.typed = 1'b1;
        it.want.kind = 1'b1;
        it.want.rtt_us = 48'sh800000000000;
        it.want.offset_us = 48'sh7fffffffffff;
        rows[n_rows] = it;
        n_rows++;
        rows[n_rows] = mk(ACT_BAD, 6'd0, '1, '1, '1, '1);
        n_rows++;
        rows[n_rows] = mk(prt_pkg::ACT_END, 6'd5, 0, 0, 0, 0);
        n_rows++;
        rows[n_rows] = mk(prt_pkg::ACT_PING, 6'd2, '1, 64'h0000_0005_000F_423F, 0, 0);
        n_rows++;
        rows[n_rows] = mk(prt_pkg::ACT_PONG, 6'd2, 2, 64'h0000_0005_FFFF_FFFF,
                          64'h0000_0005_000F_423F, 64'hFFFF_FFFF_0000_0000);
        n_rows++;
        rows[n_rows] = mk(prt_pkg::ACT_PONG, 6'd2, '1, 64'h0000_0100_0000_0000,
                          64'h0000_0200_0000_0000, 64'h0000_0001_0000_0001);
        n_rows++;
        rows[n_rows] = mk(prt_pkg::ACT_PING, 6'd2, 0, 64'h0000_0300_0000_0000, 0, 0);
        n_rows++;
        rows[n_rows] = mk(prt_pkg::ACT_PING, 6'd2, 0, 64'h0000_0301_0000_0000, 0, 0);
        n_rows++;
        for (int i = 0; i < n_rows; i++)
        begin
            send_item(rows[i]);
        end
        drain();

        idle_on = 1'b1;
        random_part(250, 1000000);
        long_hold_req = 1'b1;
        random_part(60, 200000000);
        drain();

        set_config(40'd0, 8'd0);
        random_part(250, 300000000);
        drain();

        set_config('1, 8'd255);
        random_part(150, 300000000);
        drain();

        set_config(40'd50000000, 8'd149);
        random_part(250, 100000000);
        idle_on = 1'b0;
        random_part(220, 100000000);
        drain();

        $display("Covered %0d items and %0d results over four register settings,",
                 items_sent, results_seen);
        $display("with %0d valid means and %0d shift alarms.", valid_means, alarms_seen);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
